[sv/dmh_pkg.sv]
// package for the deadline min-heap: widths, codes, beat types, controller states, datapath commands and status
// no dependencies
`default_nettype none
package dmh_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int DL_BITS_DEF = 64;
  localparam int NUM_IDS = 64;
  localparam int ID_W = 6;
  localparam int IN_DL_W = 64;
  localparam int OCC_W = 7;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_POP = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_ABSENT = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  // request and result beats
  typedef struct packed {
    logic [1:0] action;
    logic [ID_W-1:0] timer_id;
    logic [IN_DL_W-1:0] new_deadline;
  } timer_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic new_at_root;
    logic top_valid;
    logic [ID_W-1:0] top_id;
    logic [IN_DL_W-1:0] top_deadline;
    logic [OCC_W-1:0] occupancy;
  } timer_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD_LAST,
    S_LAST_WAIT,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_PLACE,
    S_TOP_RD,
    S_TOP_WAIT,
    S_OUT
  } state_t;

  // datapath commands
  typedef enum logic [3:0] {
    C_NONE,
    C_LATCH,
    C_CHECK,
    C_RD_LAST,
    C_TAKE_LAST,
    C_UP_RD,
    C_UP_CMP,
    C_DN_RD,
    C_DN_CMP,
    C_PLACE,
    C_TOP_RD,
    C_TOP_TAKE
  } cmd_t;

  typedef struct packed {
    logic err;        // check found an error
    logic done_early; // nothing to sift (pop/remove of last slot, or nop)
    logic go_up;      // sift up
    logic stop;       // sift read/compare: stop here
  } dp_status_t;
endpackage
`default_nettype wire

[sv/dmh_if.sv]
// valid/ready channel carrying one beat of payload of type T
// no dependencies
`default_nettype none
interface dmh_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/dmh_ctrl.sv]
// controller for the deadline min-heap: sequences check, sift and result
// depends on dmh_pkg
`default_nettype none
module dmh_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input wire logic out_ready,
  input wire dmh_pkg::dp_status_t st,
  output dmh_pkg::cmd_t cmd
);
  import dmh_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = C_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = C_LATCH;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd = C_CHECK;
        if (st.err || st.done_early) state_next = S_TOP_RD;
        else if (st.go_up) state_next = S_UP_RD;
        else state_next = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd = C_RD_LAST;
        state_next = S_LAST_WAIT;
      end
      S_LAST_WAIT: begin
        cmd = C_TAKE_LAST;
        state_next = st.go_up ? S_UP_RD : S_DN_RD;
      end
      S_UP_RD: begin
        cmd = C_UP_RD;
        state_next = st.stop ? S_PLACE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd = C_UP_CMP;
        state_next = st.stop ? S_PLACE : S_UP_RD;
      end
      S_DN_RD: begin
        cmd = C_DN_RD;
        state_next = st.stop ? S_PLACE : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd = C_DN_CMP;
        state_next = st.stop ? S_PLACE : S_DN_RD;
      end
      S_PLACE: begin
        cmd = C_PLACE;
        state_next = S_TOP_RD;
      end
      S_TOP_RD: begin
        cmd = C_TOP_RD;
        state_next = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        cmd = C_TOP_TAKE;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[sv/dmh_dp.sv]
// datapath for the deadline min-heap: slot memories, id map, presence, count
// depends on dmh_pkg
`default_nettype none
module dmh_dp #(
  parameter int CAPACITY = dmh_pkg::CAPACITY_DEF,
  parameter int DL_BITS = dmh_pkg::DL_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire dmh_pkg::cmd_t cmd,
  output dmh_pkg::dp_status_t st,
  input wire logic [1:0] in_action,
  input wire logic [dmh_pkg::ID_W-1:0] in_id,
  input wire logic [dmh_pkg::IN_DL_W-1:0] in_dl,
  output logic [1:0] status,
  output logic new_at_root,
  output logic top_valid,
  output logic [dmh_pkg::ID_W-1:0] top_id,
  output logic [dmh_pkg::IN_DL_W-1:0] top_deadline,
  output logic [dmh_pkg::OCC_W-1:0] occupancy
);
  import dmh_pkg::*;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;
  localparam int SW = ID_W + DL_BITS;

  // slot memory: id and deadline, one write port, two registered read ports
  logic [SW-1:0] slots [CAPACITY];
  logic [AW-1:0] id_map [NUM_IDS];
  logic [NUM_IDS-1:0] present;
  logic [CW-1:0] count;

  logic [1:0] act;
  logic [ID_W-1:0] cid;
  logic [DL_BITS-1:0] cdl;
  logic [AW-1:0] pos;
  logic [1:0] stat;
  logic at_root;
  logic [ID_W-1:0] top_id_q;
  logic [DL_BITS-1:0] top_dl_q;

  logic [AW-1:0] ra0, ra1;
  logic [SW-1:0] rd0, rd1;
  logic we;
  logic [AW-1:0] wa;
  logic [SW-1:0] wd;
  logic map_we;
  logic [ID_W-1:0] map_wa;
  logic [AW-1:0] map_q;

  // sift helpers
  logic [AW-1:0] par;
  logic [LW-1:0] lc, rc, cnt_l;
  logic [ID_W-1:0] id0;
  logic [DL_BITS-1:0] d0, d1;
  logic right_pick;
  logic [SW-1:0] pick;
  logic [AW-1:0] pick_pos;
  logic up_stop, dn_stop;

  always_ff @(posedge clk) begin
    if (we) slots[wa] <= wd;
    rd0 <= slots[ra0];
    rd1 <= slots[ra1];
  end

  always_ff @(posedge clk) begin
    if (map_we) id_map[map_wa] <= pos;
    if (cmd == C_LATCH) map_q <= id_map[in_id];
  end

  assign par = (pos - AW'(1)) >> 1;
  assign lc = {1'b0, pos, 1'b1};
  assign rc = lc + LW'(1);
  assign cnt_l = LW'(count);
  assign id0 = rd0[SW-1:DL_BITS];
  assign d0 = rd0[DL_BITS-1:0];
  assign d1 = rd1[DL_BITS-1:0];
  assign right_pick = (rc < cnt_l) && (d0 > d1);
  assign pick = right_pick ? rd1 : rd0;
  assign pick_pos = right_pick ? AW'(rc) : AW'(lc);
  assign up_stop = (d0 <= cdl);
  assign dn_stop = (cdl <= pick[DL_BITS-1:0]);

  always_comb begin
    st = '0;
    ra0 = '0;
    ra1 = '0;
    we = 1'b0;
    wa = pos;
    wd = {cid, cdl};
    map_we = 1'b0;
    map_wa = cid;
    case (cmd)
      C_CHECK: begin
        case (act)
          ACT_ADD: begin
            st.err = (count >= CW'(CAPACITY)) || present[cid];
            st.go_up = 1'b1;
          end
          ACT_REMOVE: begin
            st.err = !present[cid] || (CW'(map_q) >= count);
            st.done_early = (CW'(map_q) == count - CW'(1));
          end
          ACT_POP: begin
            st.err = (count == '0);
            st.done_early = (count == CW'(1));
          end
          default: st.done_early = 1'b1;
        endcase
      end
      C_RD_LAST: begin
        ra0 = AW'(count);
        ra1 = par;
      end
      C_TAKE_LAST: st.go_up = (pos != '0) && (d1 > d0);
      C_UP_RD: begin
        st.stop = (pos == '0);
        ra0 = par;
      end
      C_UP_CMP: begin
        st.stop = up_stop;
        if (!up_stop) begin
          we = 1'b1;
          wd = rd0;
          map_we = 1'b1;
          map_wa = id0;
        end
      end
      C_DN_RD: begin
        st.stop = (lc >= cnt_l);
        ra0 = AW'(lc);
        ra1 = AW'(rc);
      end
      C_DN_CMP: begin
        st.stop = dn_stop;
        if (!dn_stop) begin
          we = 1'b1;
          wd = pick;
          map_we = 1'b1;
          map_wa = pick[SW-1:DL_BITS];
        end
      end
      C_PLACE: begin
        we = 1'b1;
        map_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      count <= '0;
    end else begin
      case (cmd)
        C_LATCH: begin
          act <= in_action;
          cid <= in_id;
          cdl <= in_dl[DL_BITS-1:0];
          stat <= ST_OK;
          at_root <= 1'b0;
        end
        C_CHECK: begin
          if (st.err) begin
            if (act == ACT_ADD) stat <= (count >= CW'(CAPACITY)) ? ST_FULL : ST_PRESENT;
            else stat <= ST_ABSENT;
          end else if (act == ACT_ADD) begin
            present[cid] <= 1'b1;
            count <= count + CW'(1);
            pos <= AW'(count);
          end else if (act == ACT_REMOVE) begin
            present[cid] <= 1'b0;
            count <= count - CW'(1);
            pos <= map_q;
          end else if (act == ACT_POP) begin
            present[id0] <= 1'b0;
            count <= count - CW'(1);
            pos <= '0;
          end
        end
        C_TAKE_LAST: begin
          cid <= id0;
          cdl <= d0;
        end
        C_UP_CMP: if (!up_stop) pos <= par;
        C_DN_CMP: if (!dn_stop) pos <= pick_pos;
        C_PLACE: at_root <= (act == ACT_ADD) && (pos == '0);
        C_TOP_TAKE: begin
          top_id_q <= id0;
          top_dl_q <= d0;
        end
        default: ;
      endcase
    end
  end

  assign status = stat;
  assign new_at_root = at_root;
  assign occupancy = OCC_W'(count);
  assign top_valid = (count != '0);
  assign top_id = top_valid ? top_id_q : '0;
  assign top_deadline = top_valid ? IN_DL_W'(top_dl_q) : '0;
endmodule
`default_nettype wire

[sv/deadline_min_heap_top.sv]
// top level of the deadline min-heap timer queue, depends on dmh_pkg, dmh_if, dmh_ctrl, dmh_dp
// one item at a time: a new request is taken only in idle; with no sift (error, nop,
// removal of the last slot) the check leads straight to the top read and the result,
// else each sift level costs a read and a compare before the entry is placed
// the result beat holds until taken and output stalls delay the next accept
// synchronous reset empties the heap; slot memories are not cleared
`default_nettype none
module deadline_min_heap_top #(
  parameter int CAPACITY = dmh_pkg::CAPACITY_DEF,
  parameter int DL_BITS = dmh_pkg::DL_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  dmh_if.sink req,
  dmh_if.source rsp
);
  import dmh_pkg::*;
  dp_status_t st;
  cmd_t cmd;

  dmh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .st(st), .cmd(cmd)
  );

  dmh_dp #(.CAPACITY(CAPACITY), .DL_BITS(DL_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .in_action(req.data.action), .in_id(req.data.timer_id),
    .in_dl(req.data.new_deadline),
    .status(rsp.data.status), .new_at_root(rsp.data.new_at_root),
    .top_valid(rsp.data.top_valid), .top_id(rsp.data.top_id),
    .top_deadline(rsp.data.top_deadline), .occupancy(rsp.data.occupancy)
  );
endmodule
`default_nettype wire
